/* src/jtdm_pkg.sv */
// jtdm_pkg: shared constants, types and codes of the joystick tank drive mixer.
// No dependencies; every other file of the block imports it.
package jtdm_pkg;

    localparam int MAX_GEAR_DEF = 4;

    localparam int AXIS_W = 12;              // raw axis and register width
    localparam int DUTY_W = 12;              // duty output width
    localparam int GEAR_OUT_W = 3;           // gear_now width
    localparam int IDX_W = 2;                // register index width

    localparam int DIV_NUM_W = 23;           // (raw - c) * 2048 needs 23 bits
    localparam int DIV_SHORT_W = 13;         // track magnitude up to 4096
    localparam int DIV_DEN_W = 12;
    localparam int DIV_Q_W = 13;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    localparam logic [AXIS_W-1:0] RAW_MAX = 12'd4095;
    localparam logic [AXIS_W-1:0] CENTER_MIN = 12'd1;
    localparam logic [AXIS_W-1:0] CENTER_MAX = 12'd4094;
    localparam logic [AXIS_W-1:0] FULL_SCALE = 12'd2048;

    localparam logic [AXIS_W-1:0] CENTER_RST = 12'd2048;
    localparam logic [AXIS_W-1:0] DEAD_HIGH_RST = 12'd300;
    localparam logic [AXIS_W-1:0] DEAD_LOW_RST = 12'd200;

    // register indexes
    localparam logic [IDX_W-1:0] REG_CENTER_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_DEAD_HIGH = 2'd2;
    localparam logic [IDX_W-1:0] REG_DEAD_LOW = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP_GO,
        S_MAP_WAIT,
        S_MIX,
        S_TRK_GO,
        S_TRK_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;          // latch the frame, update gear and button history
        logic start_map;     // start the axis divisions
        logic start_trk;     // start the track divisions by the gear
        logic mix;           // dead zone and track mix
        logic out_load;      // load the result word
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_stat_t;

endpackage

/* src/jtdm_if.sv */
// jtdm_if: valid/ready channels of the mixer: frame in, duty out, register write.
// Depends on jtdm_pkg for field widths.
interface jtdm_frame_if
    import jtdm_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [AXIS_W-1:0] x_raw;
    logic [AXIS_W-1:0] y_raw;
    logic              slower_button;
    logic              faster_button;

    modport source (output valid, x_raw, y_raw, slower_button, faster_button, input ready);
    modport sink (input valid, x_raw, y_raw, slower_button, faster_button, output ready);
endinterface

interface jtdm_duty_if
    import jtdm_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic [DUTY_W-1:0]     right_forward;
    logic [DUTY_W-1:0]     right_reverse;
    logic [DUTY_W-1:0]     left_forward;
    logic [DUTY_W-1:0]     left_reverse;
    logic [GEAR_OUT_W-1:0] gear_now;

    modport source (output valid, right_forward, right_reverse, left_forward, left_reverse,
                    gear_now, input ready);
    modport sink (input valid, right_forward, right_reverse, left_forward, left_reverse,
                  gear_now, output ready);
endinterface

interface jtdm_cfg_if
    import jtdm_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [AXIS_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* src/jtdm_div.sv */
// jtdm_div: restoring divider, one quotient bit per cycle, 23 or 13 steps.
// Depends on jtdm_pkg for widths.
module jtdm_div
    import jtdm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 short_op,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic [DIV_Q_W-1:0]   quo,
    output logic                 done
);

    logic [DIV_NUM_W-1:0] nq_reg, nq_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    // shift in the next numerator bit and try a subtraction
    assign trial = {rem_reg, nq_reg[DIV_NUM_W-1]};
    assign fits = trial >= {1'b0, den_reg};

    always_comb
    begin
        nq_next = nq_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            // short operands are pre-aligned to the top so fewer steps suffice
            nq_next = short_op ? {num[DIV_SHORT_W-1:0], (DIV_NUM_W - DIV_SHORT_W)'(0)} : num;
            rem_next = '0;
            den_next = den;
            cnt_next = short_op ? DIV_CNT_W'(DIV_SHORT_W) : DIV_CNT_W'(DIV_NUM_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            nq_next = {nq_reg[DIV_NUM_W-2:0], fits};
            rem_next = fits ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nq_reg <= nq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quo = nq_reg[DIV_Q_W-1:0];
    assign done = done_reg;

endmodule

/* src/jtdm_ctrl.sv */
// jtdm_ctrl: sequencing state machine of the mixer and the result valid flag.
// Depends on jtdm_pkg for state, command and status types.
module jtdm_ctrl
    import jtdm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (in_valid) state_next = S_MAP_GO;
            S_MAP_GO:   state_next = S_MAP_WAIT;
            S_MAP_WAIT: if (stat.div_done) state_next = S_MIX;
            S_MIX:      state_next = S_TRK_GO;
            S_TRK_GO:   state_next = S_TRK_WAIT;
            S_TRK_WAIT: if (stat.div_done) state_next = S_DONE;
            S_DONE:     if (slot_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_MAP_GO:   cmd.start_map = 1'b1;
            S_MIX:      cmd.mix = 1'b1;
            S_TRK_GO:   cmd.start_trk = 1'b1;
            S_DONE:     cmd.out_load = slot_free;
            default:    cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // a result word never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result word overwritten while stalled");

    // an accepted frame always starts the axis divisions next
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> cmd.start_map)
        else $error("accepted frame did not start the divider");

    // a divider start always clears its done flag
    a_start_clears_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start_map || cmd.start_trk) |=> !stat.div_done)
        else $error("divider done flag not cleared by start");

    // a result is only loaded after the track divisions finished
    a_load_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.div_done)
        else $error("result loaded before the divisions finished");

endmodule

/* src/jtdm_dp.sv */
// jtdm_dp: mixer datapath: registers, gear state, axis mapping, dead zone, mix, duties.
// Depends on jtdm_pkg and the divider jtdm_div.
module jtdm_dp
    import jtdm_pkg::*;
#(
    parameter int MAX_GEAR = MAX_GEAR_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic [AXIS_W-1:0]     x_raw,
    input  logic [AXIS_W-1:0]     y_raw,
    input  logic                  slower_button,
    input  logic                  faster_button,
    input  logic                  cfg_we,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [AXIS_W-1:0]     cfg_data,
    output logic [DUTY_W-1:0]     right_forward,
    output logic [DUTY_W-1:0]     right_reverse,
    output logic [DUTY_W-1:0]     left_forward,
    output logic [DUTY_W-1:0]     left_reverse,
    output logic [GEAR_OUT_W-1:0] gear_now
);

    localparam int GEAR_W = $clog2(MAX_GEAR + 1);

    // configuration
    logic [AXIS_W-1:0] center_x_reg, center_y_reg, dead_high_reg, dead_low_reg;

    // state
    logic [GEAR_W-1:0] gear_reg, gear_next, gear_up;
    logic              slower_prev_reg, faster_prev_reg;
    logic              x_dz_reg, y_dz_reg, x_dz_next, y_dz_next;

    // per-word working registers
    logic [AXIS_W-1:0]  x_raw_reg, y_raw_reg;
    logic signed [13:0] tr_reg, tl_reg, tr_next, tl_next;

    // output word
    logic [DUTY_W-1:0]     rf_reg, rr_reg, lf_reg, lr_reg;
    logic [GEAR_OUT_W-1:0] gear_out_reg;

    // dividers
    logic [DIV_NUM_W-1:0] num_x, num_y;
    logic [DIV_DEN_W-1:0] den_x, den_y;
    logic [DIV_Q_W-1:0]   q_x, q_y;
    logic                 done_x, done_y;
    logic                 div_start;

    logic [AXIS_W-1:0]  cx, cy;
    logic               gt_x, gt_y;
    logic signed [12:0] vx_map, vy_map, vx, vy;
    logic [12:0]        tr_mag, tl_mag;
    logic [DUTY_W-1:0]  r_sat, l_sat;

    function automatic logic [AXIS_W-1:0] clamp_center(input logic [AXIS_W-1:0] c);
        logic [AXIS_W-1:0] r;
        r = c;
        if (c < CENTER_MIN)
            r = CENTER_MIN;
        else if (c > CENTER_MAX)
            r = CENTER_MAX;
        return r;
    endfunction

    function automatic logic signed [12:0] map_value(input logic gt,
                                                     input logic [DIV_Q_W-1:0] q);
        logic signed [12:0] v;
        v = $signed({1'b0, q[AXIS_W-1:0]});
        if (!gt)
            v = v - $signed({1'b0, FULL_SCALE});
        return v;
    endfunction

    // hysteresis: above high releases, below low captures, between keeps
    function automatic logic dz_flag(input logic signed [12:0] v, input logic flag,
                                     input logic [AXIS_W-1:0] hi,
                                     input logic [AXIS_W-1:0] lo);
        logic [12:0] m;
        logic        f;
        m = v[12] ? 13'(-v) : 13'(v);
        f = flag;
        if (m > {1'b0, hi})
            f = 1'b0;
        else if (m < {1'b0, lo})
            f = 1'b1;
        return f;
    endfunction

    function automatic logic [12:0] abs14(input logic signed [13:0] t);
        logic signed [13:0] a;
        a = t[13] ? -t : t;
        return a[12:0];
    endfunction

    function automatic logic [DUTY_W-1:0] sat_duty(input logic [DIV_Q_W-1:0] q);
        logic [DUTY_W-1:0] d;
        d = (q > {1'b0, FULL_SCALE}) ? FULL_SCALE : q[DUTY_W-1:0];
        return d;
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= CENTER_RST;
            center_y_reg <= CENTER_RST;
            dead_high_reg <= DEAD_HIGH_RST;
            dead_low_reg <= DEAD_LOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CENTER_X:  center_x_reg <= cfg_data;
                REG_CENTER_Y:  center_y_reg <= cfg_data;
                REG_DEAD_HIGH: dead_high_reg <= cfg_data;
                REG_DEAD_LOW:  dead_low_reg <= cfg_data;
                default:       center_x_reg <= center_x_reg;
            endcase
        end
    end

    // gear: slower edge first, then faster edge, each bounded on its own
    always_comb
    begin
        gear_up = gear_reg;
        if (slower_button && !slower_prev_reg && gear_reg < GEAR_W'(MAX_GEAR))
            gear_up = gear_reg + 1'b1;
        gear_next = gear_up;
        if (faster_button && !faster_prev_reg && gear_up > GEAR_W'(1))
            gear_next = gear_up - 1'b1;
    end

    // axis mapping operands, or the track magnitudes and gear for the track divisions
    always_comb
    begin
        cx = clamp_center(center_x_reg);
        cy = clamp_center(center_y_reg);
        gt_x = x_raw_reg > cx;
        gt_y = y_raw_reg > cy;
        if (cmd.start_trk)
        begin
            num_x = DIV_NUM_W'(abs14(tr_reg));
            num_y = DIV_NUM_W'(abs14(tl_reg));
            den_x = DIV_DEN_W'(gear_reg);
            den_y = DIV_DEN_W'(gear_reg);
        end
        else
        begin
            num_x = gt_x ? {x_raw_reg - cx, 11'd0} : {x_raw_reg, 11'd0};
            num_y = gt_y ? {y_raw_reg - cy, 11'd0} : {y_raw_reg, 11'd0};
            den_x = gt_x ? RAW_MAX - cx : cx;
            den_y = gt_y ? RAW_MAX - cy : cy;
        end
    end

    assign div_start = cmd.start_map || cmd.start_trk;

    jtdm_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .short_op (cmd.start_trk),
        .num      (num_x),
        .den      (den_x),
        .quo      (q_x),
        .done     (done_x)
    );

    jtdm_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .short_op (cmd.start_trk),
        .num      (num_y),
        .den      (den_y),
        .quo      (q_y),
        .done     (done_y)
    );

    assign stat.div_done = done_x && done_y;

    // dead zone and mix
    always_comb
    begin
        vx_map = map_value(gt_x, q_x);
        vy_map = map_value(gt_y, q_y);
        x_dz_next = dz_flag(vx_map, x_dz_reg, dead_high_reg, dead_low_reg);
        y_dz_next = dz_flag(vy_map, y_dz_reg, dead_high_reg, dead_low_reg);
        vx = x_dz_next ? 13'sd0 : vx_map;
        vy = y_dz_next ? 13'sd0 : vy_map;
        tr_next = 14'(vy) + 14'(vx);
        tl_next = 14'(vy) - 14'(vx);
    end

    assign tr_mag = abs14(tr_reg);
    assign tl_mag = abs14(tl_reg);
    assign r_sat = sat_duty(q_x);
    assign l_sat = sat_duty(q_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gear_reg <= GEAR_W'(1);
            slower_prev_reg <= 1'b0;
            faster_prev_reg <= 1'b0;
            x_dz_reg <= 1'b0;
            y_dz_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                gear_reg <= gear_next;
                slower_prev_reg <= slower_button;
                faster_prev_reg <= faster_button;
            end
            if (cmd.mix)
            begin
                x_dz_reg <= x_dz_next;
                y_dz_reg <= y_dz_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_raw_reg <= x_raw;
            y_raw_reg <= y_raw;
        end
        if (cmd.mix)
        begin
            tr_reg <= tr_next;
            tl_reg <= tl_next;
        end
        if (cmd.out_load)
        begin
            // a zero track gives a zero magnitude, so both sides read 0
            rf_reg <= (!tr_reg[13] && tr_mag != 13'd0) ? r_sat : '0;
            rr_reg <= (!tr_reg[13] && tr_mag != 13'd0) ? '0 : r_sat;
            lf_reg <= (!tl_reg[13] && tl_mag != 13'd0) ? l_sat : '0;
            lr_reg <= (!tl_reg[13] && tl_mag != 13'd0) ? '0 : l_sat;
            gear_out_reg <= GEAR_OUT_W'(gear_reg);
        end
    end

    assign right_forward = rf_reg;
    assign right_reverse = rr_reg;
    assign left_forward = lf_reg;
    assign left_reverse = lr_reg;
    assign gear_now = gear_out_reg;

endmodule

/* src/joystick_tank_drive_mixer.sv */
// joystick_tank_drive_mixer: top level, joins controller, datapath and channels.
// Depends on jtdm_pkg, jtdm_if, jtdm_ctrl, jtdm_dp (which holds jtdm_div).
//
// Use: one joystick frame word enters on 'frame' (valid/ready); one duty word
// leaves on 'duty' for every frame: forward and reverse duty of each track
// (0..2048) and the gear divisor in force after the frame.
// 'cfg' writes the centre and dead zone registers by index; it is always ready.
// The user writes it only while no frame is in flight; the block does not enforce it.
// Sequence: after acceptance a frame runs through the two axis dividers (one
// quotient bit a cycle), then the same dividers divide the tracks by the gear,
// with sequencing states between, before its duty word is loaded. One frame
// is in flight at a time and the input is ready again in the cycle after the
// word is loaded, so no new frame is taken before the last word is loaded;
// throughput is limited by the shared bit-serial dividers.
// Stall: the finished word sits in an output register; the next frame is
// accepted and processed meanwhile and waits at the end until the register
// is taken.
// Reset: centres 2048, dead zone 300/200, gear 1, dead zone flags and button
// history cleared, no word pending.
module joystick_tank_drive_mixer
    import jtdm_pkg::*;
#(
    parameter int MAX_GEAR = MAX_GEAR_DEF
)
(
    input logic         clk,
    input logic         rst_n,
    jtdm_frame_if.sink  frame,
    jtdm_duty_if.source duty,
    jtdm_cfg_if.sink    cfg
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg.ready = 1'b1;

    jtdm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (frame.valid),
        .in_ready  (frame.ready),
        .out_valid (duty.valid),
        .out_ready (duty.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    jtdm_dp #(
        .MAX_GEAR (MAX_GEAR)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .x_raw         (frame.x_raw),
        .y_raw         (frame.y_raw),
        .slower_button (frame.slower_button),
        .faster_button (frame.faster_button),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .right_forward (duty.right_forward),
        .right_reverse (duty.right_reverse),
        .left_forward  (duty.left_forward),
        .left_reverse  (duty.left_reverse),
        .gear_now      (duty.gear_now)
    );

endmodule

/* dv/tb.sv */
// tb: self-checking bench for joystick_tank_drive_mixer, frame words in, duty words out.
// Needs jtdm_pkg, the channel interfaces of jtdm_if and the mixer RTL; nothing else.
`timescale 1ns / 1ps

module tb;
    import jtdm_pkg::*;

    localparam int GEAR_TOP = MAX_GEAR_DEF;
    localparam int FS = int'(FULL_SCALE);
    localparam int RAW_TOP = int'(RAW_MAX);
    localparam int CTR_LO = int'(CENTER_MIN);
    localparam int CTR_HI = int'(CENTER_MAX);
    localparam int N_DIRECTED = 26;
    localparam int N_PHASES = 9;
    localparam int PHASE_WORDS = 90;

    typedef struct packed {
        logic [AXIS_W-1:0] x_raw;
        logic [AXIS_W-1:0] y_raw;
        logic              slower;
        logic              faster;
    } frame_t;

    typedef struct packed {
        logic [DUTY_W-1:0]     right_fwd;
        logic [DUTY_W-1:0]     right_rev;
        logic [DUTY_W-1:0]     left_fwd;
        logic [DUTY_W-1:0]     left_rev;
        logic [GEAR_OUT_W-1:0] gear;
    } duty_t;

    typedef struct packed {
        frame_t stim;
        logic   typed;
        duty_t  want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;

    jtdm_frame_if frame_ch ();
    jtdm_duty_if  duty_ch ();
    jtdm_cfg_if   cfg_ch ();

    joystick_tank_drive_mixer #(.MAX_GEAR(GEAR_TOP)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .frame (frame_ch),
        .duty  (duty_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // mixer state as the block should hold it
    int ctr_x, ctr_y, dz_high, dz_low;
    int gear_div;
    bit x_dead, y_dead, slow_last, fast_last;

    duty_t duty_pending[$];
    row_t  script[N_DIRECTED];

    int errors = 0;
    int frames_sent = 0;
    int words_checked = 0;
    int settings_loaded = 0;
    bit burst = 1'b0;
    int rx_hold = 0;
    logic btn_slow, btn_fast;

    function automatic int axis_scale(int ctr, int raw);
        int c;
        c = ctr;
        if (c < CTR_LO) c = CTR_LO;
        if (c > CTR_HI) c = CTR_HI;
        if (raw > c)
            return ((raw - c) * FS) / (RAW_TOP - c);
        return (raw * FS) / c - FS;
    endfunction

    function automatic int dead_band(int v, inout bit flag);
        int mag;
        mag = (v < 0) ? -v : v;
        if (mag > dz_high)
            flag = 1'b0;
        else if (mag < dz_low)
            flag = 1'b1;
        return flag ? 0 : v;
    endfunction

    function automatic void track_duty(int t, output logic [DUTY_W-1:0] fwd,
                                       output logic [DUTY_W-1:0] rev);
        int mag;
        mag = ((t < 0) ? -t : t) / gear_div;
        if (mag > FS) mag = FS;
        if (t > 0)
        begin
            fwd = mag[DUTY_W-1:0];
            rev = '0;
        end
        else
        begin
            fwd = '0;
            rev = mag[DUTY_W-1:0];
        end
    endfunction

    // gear moves first, then both axes, then the two tracks
    function automatic duty_t mix_frame(frame_t f);
        duty_t d;
        int x, y;
        if (f.slower && !slow_last && gear_div < GEAR_TOP) gear_div++;
        slow_last = f.slower;
        if (f.faster && !fast_last && gear_div > 1) gear_div--;
        fast_last = f.faster;
        x = dead_band(axis_scale(ctr_x, int'(f.x_raw)), x_dead);
        y = dead_band(axis_scale(ctr_y, int'(f.y_raw)), y_dead);
        track_duty(y + x, d.right_fwd, d.right_rev);
        track_duty(y - x, d.left_fwd, d.left_rev);
        d.gear = gear_div[GEAR_OUT_W-1:0];
        return d;
    endfunction

    function automatic row_t mk_row(int x, int y, int s, int f, int typed,
                                    int rf, int rr, int lf, int lr, int g);
        row_t r;
        r.stim.x_raw = x[AXIS_W-1:0];
        r.stim.y_raw = y[AXIS_W-1:0];
        r.stim.slower = s[0];
        r.stim.faster = f[0];
        r.typed = typed[0];
        r.want.right_fwd = rf[DUTY_W-1:0];
        r.want.right_rev = rr[DUTY_W-1:0];
        r.want.left_fwd = lf[DUTY_W-1:0];
        r.want.left_rev = lr[DUTY_W-1:0];
        r.want.gear = g[GEAR_OUT_W-1:0];
        return r;
    endfunction

    function automatic int gap_draw();
        return burst ? 0 : int'($urandom_range(0, 16));
    endfunction

    // partly near the centre so the dead zone edges get hit, some rails, the rest uniform
    function automatic logic [AXIS_W-1:0] pick_raw(int ctr);
        int v, off;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = RAW_TOP;
            2, 3, 4:
            begin
                off = $urandom_range(0, (dz_high > 2048 ? 2048 : dz_high) * 3 / 2 + 64);
                v = $urandom_range(0, 1) ? ctr + off : ctr - off;
                if (v < 0) v = 0;
                if (v > RAW_TOP) v = RAW_TOP;
            end
            default: v = $urandom_range(0, RAW_TOP);
        endcase
        return v[AXIS_W-1:0];
    endfunction

    task automatic duty_mismatch(string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(string name, logic [DUTY_W-1:0] got, logic [DUTY_W-1:0] want);
        if (got !== want)
            duty_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task automatic send_frame(frame_t f, logic typed, duty_t want);
        int gap;
        duty_t predicted;
        gap = gap_draw();
        if (gap > 0)
        begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_ch.valid <= 1'b1;
        frame_ch.x_raw <= f.x_raw;
        frame_ch.y_raw <= f.y_raw;
        frame_ch.slower_button <= f.slower;
        frame_ch.faster_button <= f.faster;
        @(posedge clk);
        while (!frame_ch.ready) @(posedge clk);
        predicted = mix_frame(f);
        duty_pending.push_back(typed ? want : predicted);
        frames_sent++;
    endtask

    // stop offering and let every pending word come back
    task automatic drain();
        frame_ch.valid <= 1'b0;
        do @(posedge clk); while (duty_pending.size() != 0);
    endtask

    task automatic load_settings(int cx, int cy, int dh, int dl);
        int vals[4];
        logic [IDX_W-1:0] idx;
        vals = '{cx, cy, dh, dl};
        for (int i = 0; i < 4; i++)
        begin
            idx = i[IDX_W-1:0];
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx;
            cfg_ch.data <= vals[i][AXIS_W-1:0];
            @(posedge clk);
            while (!cfg_ch.ready) @(posedge clk);
            case (idx)
                REG_CENTER_X:  ctr_x = vals[i] & RAW_TOP;
                REG_CENTER_Y:  ctr_y = vals[i] & RAW_TOP;
                REG_DEAD_HIGH: dz_high = vals[i] & RAW_TOP;
                REG_DEAD_LOW:  dz_low = vals[i] & RAW_TOP;
                default: ;
            endcase
        end
        cfg_ch.valid <= 1'b0;
        settings_loaded++;
    endtask

    // duty side: random stalls, one long hold-off on request
    initial
    begin
        int stall;
        duty_t got, want;
        duty_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                stall = rx_hold;
                rx_hold = 0;
            end
            else
                stall = gap_draw();
            if (stall > 0)
            begin
                duty_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            duty_ch.ready <= 1'b1;
            @(posedge clk);
            while (!duty_ch.valid) @(posedge clk);
            got.right_fwd = duty_ch.right_forward;
            got.right_rev = duty_ch.right_reverse;
            got.left_fwd = duty_ch.left_forward;
            got.left_rev = duty_ch.left_reverse;
            got.gear = duty_ch.gear_now;
            if (duty_pending.size() == 0)
                duty_mismatch("duty word with nothing pending");
            else
            begin
                want = duty_pending.pop_front();
                check_field("right_forward", got.right_fwd, want.right_fwd);
                check_field("right_reverse", got.right_rev, want.right_rev);
                check_field("left_forward", got.left_fwd, want.left_fwd);
                check_field("left_reverse", got.left_rev, want.left_rev);
                check_field("gear_now", DUTY_W'(got.gear), DUTY_W'(want.gear));
                words_checked++;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb: timeout with %0d words pending", duty_pending.size());
        $display("tb: errors");
        $finish;
    end

    initial
    begin
        int cx, cy, dh, dl;
        frame_t f;
        duty_t none;

        rst_n <= 1'b0;
        frame_ch.valid <= 1'b0;
        frame_ch.x_raw <= '0;
        frame_ch.y_raw <= '0;
        frame_ch.slower_button <= 1'b0;
        frame_ch.faster_button <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_CENTER_X;
        cfg_ch.data <= '0;
        none = '0;

        ctr_x = int'(CENTER_RST);
        ctr_y = int'(CENTER_RST);
        dz_high = int'(DEAD_HIGH_RST);
        dz_low = int'(DEAD_LOW_RST);
        gear_div = 1;
        x_dead = 1'b0;
        y_dead = 1'b0;
        slow_last = 1'b0;
        fast_last = 1'b0;

        // x, y, slower, faster, typed, rf, rr, lf, lr, gear
        script = '{
            mk_row(2048, 2048, 0, 0, 1,    0,    0,    0,    0, 1), // centred after reset
            mk_row(2048, 4095, 0, 0, 1, 2048,    0, 2048,    0, 1), // full throttle
            mk_row(2048,    0, 0, 0, 1,    0, 2048,    0, 2048, 1), // full reverse
            mk_row(4095, 2048, 0, 0, 1, 2048,    0,    0, 2048, 1), // spin right
            mk_row(   0, 2048, 0, 0, 1,    0, 2048, 2048,    0, 1), // spin left
            mk_row(4095, 4095, 0, 0, 1, 2048,    0,    0,    0, 1), // right saturates, left zero
            mk_row(   0,    0, 0, 0, 1,    0, 2048,    0,    0, 1),
            mk_row(2298, 2048, 0, 1, 0, 0, 0, 0, 0, 0), // between thresholds; faster at gear 1
            mk_row(2198, 2048, 0, 0, 0, 0, 0, 0, 0, 0), // into the dead zone
            mk_row(2298, 2048, 1, 0, 0, 0, 0, 0, 0, 0), // stays dead
            mk_row(2400, 2048, 1, 0, 0, 0, 0, 0, 0, 0), // out again, slower held
            mk_row(4095,    0, 0, 0, 1,    0,    0,    0, 2048, 2),
            mk_row(3000, 1000, 1, 0, 0, 0, 0, 0, 0, 0),
            mk_row(3500,  500, 0, 0, 0, 0, 0, 0, 0, 0),
            mk_row(3500,  500, 1, 0, 0, 0, 0, 0, 0, 0),
            mk_row(2048, 2048, 0, 0, 0, 0, 0, 0, 0, 0),
            mk_row(4095, 4095, 1, 0, 1, 1024,    0,    0,    0, 4), // gear at top bound
            mk_row(2048, 2048, 1, 1, 0, 0, 0, 0, 0, 0),
            mk_row( 100, 4000, 0, 0, 0, 0, 0, 0, 0, 0),
            mk_row(3000, 3000, 1, 1, 0, 0, 0, 0, 0, 0), // both buttons rise
            mk_row(2048, 2048, 0, 0, 0, 0, 0, 0, 0, 0),
            mk_row(   0, 4095, 0, 1, 0, 0, 0, 0, 0, 0),
            mk_row(2048, 2048, 0, 0, 0, 0, 0, 0, 0, 0),
            mk_row(   0, 4095, 0, 1, 0, 0, 0, 0, 0, 0),
            mk_row(2048, 2048, 0, 0, 0, 0, 0, 0, 0, 0),
            mk_row(4095, 4095, 1, 1, 1, 2048,    0,    0,    0, 1)  // both rise at gear 1
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            send_frame(script[i].stim, script[i].typed, script[i].want);
        btn_slow = 1'b1;
        btn_fast = 1'b1;

        for (int p = 0; p < N_PHASES; p++)
        begin
            drain();
            case (p)
                0: begin cx = CTR_LO; cy = CTR_HI; dh = FS; dl = 0; end
                1: begin cx = CTR_HI; cy = CTR_LO; dh = 0; dl = FS; end
                2:
                begin
                    // centre registers outside the legal range get clamped
                    cx = 0;
                    cy = RAW_TOP;
                    dl = $urandom_range(0, 400);
                    dh = dl + $urandom_range(0, 300);
                end
                N_PHASES - 1:
                begin
                    cx = int'(CENTER_RST);
                    cy = int'(CENTER_RST);
                    dh = int'(DEAD_HIGH_RST);
                    dl = int'(DEAD_LOW_RST);
                end
                default:
                begin
                    cx = $urandom_range(CTR_LO, CTR_HI);
                    cy = $urandom_range(CTR_LO, CTR_HI);
                    if ($urandom_range(0, 3) == 0)
                    begin
                        dh = $urandom_range(0, RAW_TOP);
                        dl = $urandom_range(0, RAW_TOP);
                    end
                    else
                    begin
                        dl = $urandom_range(0, 600);
                        dh = dl + $urandom_range(0, 400);
                    end
                end
            endcase
            load_settings(cx, cy, dh, dl);

            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (n % 32 == 0)
                    burst = ($urandom_range(0, 3) == 0);
                // long stall on the duty side so the input backs up
                if (p == 4 && n == 10)
                    rx_hold = 400;
                if ($urandom_range(0, 3) == 0) btn_slow = ~btn_slow;
                if ($urandom_range(0, 3) == 0) btn_fast = ~btn_fast;
                f.x_raw = pick_raw(ctr_x);
                f.y_raw = pick_raw(ctr_y);
                f.slower = btn_slow;
                f.faster = btn_fast;
                send_frame(f, 1'b0, none);
            end
        end

        drain();
        repeat (64) @(posedge clk);
        $display("tb: %0d frames sent, %0d duty words checked", frames_sent, words_checked);
        $display("tb: %0d register settings, dead zone, gear bounds and saturation exercised",
                 settings_loaded);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
